// ===== design/sgm_pkg.sv =====
package sgm_pkg;

    // field widths
    localparam int PIX_W     = 8;
    localparam int GRAD_W    = 11;
    localparam int ABS_W     = 10;
    localparam int MAG_W     = 8;
    localparam int DIR_W     = 2;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     CFG_WIDTH_RST  = 11'd512;
    localparam logic [CFG_W-1:0]     CFG_HEIGHT_RST = 11'd512;

    // magnitude saturation
    localparam logic [MAG_W-1:0] MAG_MAX = 8'd255;

    // queue between front and back, depth is a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_HORIZ = 2'd0,
        DIR_SLASH = 2'd1,
        DIR_VERT  = 2'd2,
        DIR_BSLASH = 2'd3
    } t_dir;

    // per-item classification made by the front
    typedef struct packed {
        logic emit;
        logic last;
        logic pad_top;
        logic pad_bottom;
        logic pad_left;
        logic pad_right;
    } t_class;

    // padded 3x3 window queued for the back, px[row][col]
    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] px;
        logic                       last;
    } t_item;

    // queue status seen by front and back
    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               empty;
    } t_q_status;

endpackage

// ===== design/sgm_front.sv =====
module sgm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [sgm_pkg::PIX_W-1:0]              i_pixel,
    input  logic                                   i_flush,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]       i_width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]      i_height,
    input  sgm_pkg::t_q_status                     i_q_status,
    output logic                                   o_push,
    output sgm_pkg::t_item                         o_item
);
    import sgm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 3);

    // position state
    logic [CW-1:0]    r_col, n_col;
    logic [HW-1:0]    r_row, n_row;

    // line stores
    logic [PIX_W-1:0] r_upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] r_middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd_upper, r_rd_middle;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_upper, r_fwd_middle;

    // stage one
    logic             r_s1_valid;
    logic [CW-1:0]    r_s1_x;
    logic [PIX_W-1:0] r_s1_data;
    t_class           r_s1_class;

    // window
    logic [2:0][2:0][PIX_W-1:0] r_win, n_win;

    logic             accept;
    logic [CW-1:0]    cur_x;
    logic [HW-1:0]    cur_y;
    logic [HW-1:0]    h_ext, h_plus1;
    logic [WW-1:0]    x_plus1;
    logic [PIX_W-1:0] cur_data;
    t_class           cur_class;
    logic [PIX_W-1:0] s1_top, s1_mid;

    // keep room for the item in stage one and the one being taken
    assign o_ready = (i_q_status.count <= Q_CNT_W'(Q_DEPTH - 2));
    assign accept  = i_valid && o_ready;

    assign h_ext   = HW'(i_height);
    assign h_plus1 = h_ext + HW'(1);

    // position of the current item, wrapped and clamped to the frame
    always_comb begin
        cur_x = r_col;
        cur_y = r_row;
        if (WW'(r_col) >= i_width) begin
            cur_x = '0;
            cur_y = r_row + HW'(1);
        end
        if (cur_y > h_plus1) begin
            cur_y = h_plus1;
            cur_x = '0;
        end
    end

    // classification and zero padding of the result this item completes
    always_comb begin
        cur_data             = (i_flush || cur_y >= h_ext) ? '0 : i_pixel;
        cur_class.last       = (cur_y == h_plus1);
        cur_class.emit       = (cur_y >= HW'(2)) || (cur_y == HW'(1) && cur_x != '0);
        cur_class.pad_right  = (cur_x == '0);
        if (cur_x == '0) begin
            cur_class.pad_top    = (cur_y == HW'(2));
            cur_class.pad_bottom = (cur_y >= h_plus1);
            cur_class.pad_left   = (i_width == WW'(1));
        end else begin
            cur_class.pad_top    = (cur_y == HW'(1));
            cur_class.pad_bottom = (cur_y >= h_ext);
            cur_class.pad_left   = (cur_x == CW'(1));
        end
    end

    // next position
    assign x_plus1 = WW'(cur_x) + WW'(1);
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (cur_class.last) begin
                n_col = '0;
                n_row = '0;
            end else if (x_plus1 >= i_width) begin
                n_col = '0;
                n_row = cur_y + HW'(1);
            end else begin
                n_col = x_plus1[CW-1:0];
                n_row = cur_y;
            end
        end
    end

    // line data for stage one, bypassing the write still in flight
    assign s1_top = r_fwd ? r_fwd_upper  : r_rd_upper;
    assign s1_mid = r_fwd ? r_fwd_middle : r_rd_middle;

    // window shift
    always_comb begin
        n_win = r_win;
        if (r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                n_win[r][0] = r_win[r][1];
                n_win[r][1] = r_win[r][2];
            end
            n_win[0][2] = s1_top;
            n_win[1][2] = s1_mid;
            n_win[2][2] = r_s1_data;
        end
    end

    // padded window toward the queue
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                o_item.px[r][c] = n_win[r][c];
                if ((r == 0 && r_s1_class.pad_top) || (r == 2 && r_s1_class.pad_bottom) ||
                    (c == 0 && r_s1_class.pad_left) || (c == 2 && r_s1_class.pad_right)) begin
                    o_item.px[r][c] = '0;
                end
            end
        end
        o_item.last = r_s1_class.last;
    end

    assign o_push = r_s1_valid && r_s1_class.emit;

    // line store read and write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_upper   <= r_upper_mem[cur_x];
            r_rd_middle  <= r_middle_mem[cur_x];
            r_fwd_upper  <= s1_mid;
            r_fwd_middle <= r_s1_data;
        end
        if (r_s1_valid) begin
            r_upper_mem[r_s1_x]  <= s1_mid;
            r_middle_mem[r_s1_x] <= r_s1_data;
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x     <= cur_x;
            r_s1_data  <= cur_data;
            r_s1_class <= cur_class;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_win      <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= accept;
            r_fwd      <= accept && r_s1_valid && (r_s1_x == cur_x);
            r_win      <= n_win;
        end
    end

endmodule

// ===== design/sgm_queue.sv =====
module sgm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sgm_pkg::t_item     i_item,
    input  logic               i_pop,
    output sgm_pkg::t_item     o_head,
    output sgm_pkg::t_q_status o_status
);
    import sgm_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count, n_count;
    logic                do_pop;

    assign do_pop          = i_pop && (r_count != '0);
    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.count  = r_count;
    assign o_status.empty  = (r_count == '0);

    // occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, do_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== design/sgm_back.sv =====
module sgm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sgm_pkg::t_item                    i_head,
    input  sgm_pkg::t_q_status                i_q_status,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [sgm_pkg::GRAD_W-1:0] o_grad_x,
    output logic signed [sgm_pkg::GRAD_W-1:0] o_grad_y,
    output logic [sgm_pkg::MAG_W-1:0]         o_magnitude,
    output logic [sgm_pkg::DIR_W-1:0]         o_direction,
    output logic                              o_frame_end
);
    import sgm_pkg::*;

    // gradient stage
    logic                     r_g_valid;
    logic signed [GRAD_W-1:0] r_gx, r_gy;
    logic                     r_g_last;

    // output register
    logic                     r_o_valid;
    logic signed [GRAD_W-1:0] r_o_gx, r_o_gy;
    logic [MAG_W-1:0]         r_o_mag;
    t_dir                     r_o_dir;
    logic                     r_o_last;

    logic                     out_free, g_load;
    logic [GRAD_W-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
    logic [ABS_W-1:0]         ax, ay;
    logic [ABS_W:0]           sum;
    logic [13:0]              ay5, ax2, ax12;
    logic [MAG_W-1:0]         mag;
    t_dir                     dir;

    assign out_free = !r_o_valid || i_ready;
    assign g_load   = !r_g_valid || out_free;
    assign o_pop    = g_load && !i_q_status.empty;

    // sobel sums of the padded window
    always_comb begin
        gx_pos = GRAD_W'(i_head.px[0][2]) + GRAD_W'({i_head.px[1][2], 1'b0})
               + GRAD_W'(i_head.px[2][2]);
        gx_neg = GRAD_W'(i_head.px[0][0]) + GRAD_W'({i_head.px[1][0], 1'b0})
               + GRAD_W'(i_head.px[2][0]);
        gy_pos = GRAD_W'(i_head.px[2][0]) + GRAD_W'({i_head.px[2][1], 1'b0})
               + GRAD_W'(i_head.px[2][2]);
        gy_neg = GRAD_W'(i_head.px[0][0]) + GRAD_W'({i_head.px[0][1], 1'b0})
               + GRAD_W'(i_head.px[0][2]);
    end

    // magnitude and direction from the gradients
    always_comb begin
        ax   = ABS_W'(r_gx[GRAD_W-1] ? -r_gx : r_gx);
        ay   = ABS_W'(r_gy[GRAD_W-1] ? -r_gy : r_gy);
        sum  = {1'b0, ax} + {1'b0, ay};
        mag  = (sum > (ABS_W+1)'(MAG_MAX)) ? MAG_MAX : sum[MAG_W-1:0];
        ay5  = 14'({ay, 2'b00}) + 14'(ay);
        ax2  = 14'({ax, 1'b0});
        ax12 = 14'({ax, 3'b000}) + 14'({ax, 2'b00});
        if (ax == '0 && ay == '0) begin
            dir = DIR_HORIZ;
        end else if (ay5 < ax2) begin
            dir = DIR_HORIZ;
        end else if (ay5 > ax12) begin
            dir = DIR_VERT;
        end else if (r_gx[GRAD_W-1] == r_gy[GRAD_W-1]) begin
            dir = DIR_BSLASH;
        end else begin
            dir = DIR_SLASH;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_gx     <= $signed(gx_pos - gx_neg);
            r_gy     <= $signed(gy_pos - gy_neg);
            r_g_last <= i_head.last;
        end
        if (out_free) begin
            r_o_gx   <= r_gx;
            r_o_gy   <= r_gy;
            r_o_mag  <= mag;
            r_o_dir  <= dir;
            r_o_last <= r_g_last;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (g_load) begin
                r_g_valid <= o_pop;
            end
            if (out_free) begin
                r_o_valid <= r_g_valid;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_grad_x    = r_o_gx;
    assign o_grad_y    = r_o_gy;
    assign o_magnitude = r_o_mag;
    assign o_direction = r_o_dir;
    assign o_frame_end = r_o_last;

endmodule

// ===== design/sobel_gradient_magnitude_direction_core.sv =====
// path: after the transfer of the pixel one row plus one pixel below and right of
// its center, a result passes stage one, the queue, the gradient and output registers
// throughput: one pixel or drain item per cycle while o_ready is high, set by one line
// store read and one line store write per cycle and the one-result-per-cycle gradient back end
// reset: synchronous active-low, clears position, window, queue and valid flags;
// line stores are not cleared and need no clearing pass
module sobel_gradient_magnitude_direction_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [sgm_pkg::PIX_W-1:0]             i_pixel,
    input  logic                                  i_flush,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [sgm_pkg::GRAD_W-1:0]     o_grad_x,
    output logic signed [sgm_pkg::GRAD_W-1:0]     o_grad_y,
    output logic [sgm_pkg::MAG_W-1:0]             o_magnitude,
    output logic [sgm_pkg::DIR_W-1:0]             o_direction,
    output logic                                  o_frame_end,
    input  logic                                  i_cfg_we,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sgm_pkg::CFG_W-1:0]             i_cfg_data
);
    import sgm_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HHW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] r_width, r_height;
    logic [WW-1:0]    width_eff;
    logic [HHW-1:0]   height_eff;
    logic             push, pop;
    t_item            push_item, head_item;
    t_q_status        q_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_WIDTH_RST;
            r_height <= CFG_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions in use, zero acts as one and large values clamp
    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        if (r_height == '0) begin
            height_eff = HHW'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            height_eff = HHW'(MAX_HEIGHT);
        end else begin
            height_eff = HHW'(r_height);
        end
    end

    // front: position, line stores, window and padding
    sgm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_pixel    (i_pixel),
        .i_flush    (i_flush),
        .i_width    (width_eff),
        .i_height   (height_eff),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    // queue between front and back
    sgm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_status (q_status)
    );

    // back: gradients, magnitude, direction, output register
    sgm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_item),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_magnitude (o_magnitude),
        .o_direction (o_direction),
        .o_frame_end (o_frame_end)
    );

    // queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count above depth");

    // no push into a full queue without a pop
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && q_status.count == Q_CNT_W'(Q_DEPTH)) |-> pop)
        else $error("push into full queue");

    // zero gradient reports horizontal, vertical needs a vertical gradient
    a_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_grad_x == '0 && o_grad_y == '0) |-> (o_direction == DIR_HORIZ))
        else $error("direction set on zero gradient");

    a_dir_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_direction == DIR_VERT) |-> (o_grad_y != '0))
        else $error("vertical direction without vertical gradient");

endmodule
